### sv/fdr_pvalue_adjuster_macros.svh
// Assertion helpers for the FDR p-value adjuster checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef FDR_PVALUE_ADJUSTER_MACROS_SVH
`define FDR_PVALUE_ADJUSTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FDR_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("fdr check failed: same-cycle rule");

// Next-cycle implication, disabled during reset.
`define FDR_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("fdr check failed: next-cycle rule");

`endif

### sv/fdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FDR adjuster package
// Shared field widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package fdr_pkg;

  localparam int P_W   = 32;  // p-value field width
  localparam int POS_W = 6;   // term position field width

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_RK_I    = 11'b00000000010,
    S_RK_VI   = 11'b00000000100,
    S_RK_SCAN = 11'b00000001000,
    S_ADJ_RD  = 11'b00000010000,
    S_ADJ_MUL = 11'b00000100000,
    S_ADJ_DIV = 11'b00001000000,
    S_ADJ_MIN = 11'b00010000000,
    S_EM_RD   = 11'b00100000000,
    S_EM_LD   = 11'b01000000000,
    S_EM_HOLD = 11'b10000000000
  } fdr_state_t;

endpackage

### sv/fdr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FDR generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fdr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/fdr_pvalue_adjuster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FDR p-value adjuster
// Benjamini-Hochberg adjustment of a set of fixed-point p-values.
// ----------------------------------------------------------------------------
// Load up to MAX_TERMS p-values (2^FRACTION_BITS means 1.0, larger inputs
// saturate to 1.0, requests beyond MAX_TERMS are dropped), one request per
// cycle while in_stall is low; the request with last_in set starts the run.
// The block then ranks every value by one compare pass over the load memory
// (ties go to arrival order), writes it into a sorted memory, and walks the
// ranks from largest to smallest, forming floor(p*m/k) with one multiplier
// and a bit-serial divider and keeping a running minimum capped at 1.0.
// Finally it returns one result per value in sorted order, last_out set on
// the final one. Each value is ranked through read, latch and scan steps,
// then adjusted through read, multiply, divide and minimum steps (the divider
// retires one quotient bit per cycle over the 39-bit product p*m), and each
// result goes out through read, load and hold steps.
// in_stall is high for the whole run; a single read port per memory sets
// the ranking and output pace.
// ----------------------------------------------------------------------------
module fdr_pvalue_adjuster #(
  parameter int MAX_TERMS     = 64,
  parameter int FRACTION_BITS = 31
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [fdr_pkg::P_W-1:0]    in_p_value,
  input  logic                       in_last_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fdr_pkg::POS_W-1:0]  out_term_position,
  output logic [fdr_pkg::P_W-1:0]    out_adjusted_p,
  output logic                       out_last_out
);
  import fdr_pkg::*;

  localparam int AW   = $clog2(MAX_TERMS);       // store address width
  localparam int CNTW = $clog2(MAX_TERMS + 1);   // count / rank number width
  localparam int NW   = P_W + CNTW;              // product p*m width
  localparam int RW   = FRACTION_BITS + 1;       // running minimum width
  localparam int CW   = (NW > RW) ? NW : RW;     // common compare width
  localparam int BCW  = $clog2(NW);              // divider bit counter width
  localparam int SW   = P_W + AW;                // sorted entry width

  localparam logic [RW-1:0] ONE_R  = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [CW-1:0] ONE_CW = CW'(ONE_R);

  fdr_state_t       state_r, state_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;       // values loaded so far
  logic [CNTW-1:0]  m_r, m_nxt;           // size of the current set
  logic [AW-1:0]    i_r, i_nxt;           // element being ranked
  logic [AW-1:0]    j_r, j_nxt;           // element being compared
  logic [AW-1:0]    rank_r, rank_nxt;
  logic [P_W-1:0]   vi_r, vi_nxt;
  logic [CNTW-1:0]  k_r, k_nxt;           // 1-based rank under adjustment
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [NW-1:0]    quo_r, quo_nxt;       // dividend shifting into quotient
  logic [CNTW-1:0]  rem_r, rem_nxt;
  logic [BCW-1:0]   bit_r, bit_nxt;
  logic [RW-1:0]    runmin_r, runmin_nxt;
  logic [AW-1:0]    e_r, e_nxt;           // result being emitted
  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [P_W-1:0]   adj_r, adj_nxt;
  logic             olast_r, olast_nxt;

  logic             ld_we;
  logic [AW-1:0]    ld_raddr;
  logic [P_W-1:0]   ld_wdata, ld_rdata;
  logic             so_we;
  logic [AW-1:0]    so_waddr, so_raddr;
  logic [SW-1:0]    so_wdata, so_rdata;

  logic [AW-1:0]    last_idx;
  logic             j_first;
  logic [AW-1:0]    rank_inc;
  logic [CNTW:0]    trial;
  logic             ge;
  logic [RW-1:0]    min_sel;
  logic [CW-1:0]    min_ext;

  // Load memory: raw p-values by arrival order.
  fdr_ram #(.WIDTH(P_W), .DEPTH(MAX_TERMS)) u_ld_ram (
    .clk   (clk),
    .we    (ld_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (ld_wdata),
    .raddr (ld_raddr),
    .rdata (ld_rdata)
  );

  // Sorted memory: {value, arrival index}; value later replaced by result.
  fdr_ram #(.WIDTH(SW), .DEPTH(MAX_TERMS)) u_so_ram (
    .clk   (clk),
    .we    (so_we),
    .waddr (so_waddr),
    .wdata (so_wdata),
    .raddr (so_raddr),
    .rdata (so_rdata)
  );

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_term_position = pos_r;
  assign out_adjusted_p    = adj_r;
  assign out_last_out      = olast_r;

  // Saturate anything above one.
  assign ld_wdata = (CW'(in_p_value) > ONE_CW) ? ONE_CW[P_W-1:0] : in_p_value;

  assign last_idx = AW'(m_r - CNTW'(1));

  // Rank compare: j goes first on a smaller value or, on a tie, an earlier arrival.
  assign j_first  = (ld_rdata < vi_r) || ((ld_rdata == vi_r) && (j_r < i_r));
  assign rank_inc = rank_r + AW'(j_first);

  // One restoring divider step.
  assign trial = {rem_r, quo_r[NW-1]};
  assign ge    = (trial >= {1'b0, k_r});

  // Running minimum; the quotient fits RW bits whenever it wins.
  assign min_sel = (CW'(quo_r) < CW'(runmin_r)) ? RW'(quo_r) : runmin_r;
  assign min_ext = CW'(min_sel);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    m_nxt         = m_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rank_nxt      = rank_r;
    vi_nxt        = vi_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    runmin_nxt    = runmin_r;
    e_nxt         = e_r;
    out_valid_nxt = out_valid_r;
    pos_nxt       = pos_r;
    adj_nxt       = adj_r;
    olast_nxt     = olast_r;
    ld_we         = 1'b0;
    ld_raddr      = j_r;
    so_we         = 1'b0;
    so_waddr      = rank_inc;
    so_wdata      = {vi_r, i_r};
    so_raddr      = AW'(k_r - CNTW'(1));

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // Store while room is left; drop otherwise.
          if (cnt_r < CNTW'(MAX_TERMS)) begin
            ld_we   = 1'b1;
            cnt_nxt = cnt_r + CNTW'(1);
          end
          if (in_last_in) begin
            m_nxt     = (cnt_r < CNTW'(MAX_TERMS)) ? cnt_r + CNTW'(1) : cnt_r;
            i_nxt     = '0;
            state_nxt = S_RK_I;
          end
        end
      end
      S_RK_I: begin
        ld_raddr  = i_r;
        state_nxt = S_RK_VI;
      end
      S_RK_VI: begin
        vi_nxt    = ld_rdata;
        ld_raddr  = '0;
        j_nxt     = '0;
        rank_nxt  = '0;
        state_nxt = S_RK_SCAN;
      end
      S_RK_SCAN: begin
        ld_raddr = j_r + AW'(1);
        j_nxt    = j_r + AW'(1);
        rank_nxt = rank_inc;
        if (j_r == last_idx) begin
          // Place element i at its final rank.
          so_we    = 1'b1;
          so_waddr = rank_inc;
          so_wdata = {vi_r, i_r};
          i_nxt    = i_r + AW'(1);
          if (i_r == last_idx) begin
            k_nxt      = m_r;
            runmin_nxt = ONE_R;
            state_nxt  = S_ADJ_RD;
          end else begin
            state_nxt = S_RK_I;
          end
        end
      end
      S_ADJ_RD: begin
        so_raddr  = AW'(k_r - CNTW'(1));
        state_nxt = S_ADJ_MUL;
      end
      S_ADJ_MUL: begin
        quo_nxt   = NW'(so_rdata[SW-1:AW]) * NW'(m_r);
        idx_nxt   = so_rdata[AW-1:0];
        rem_nxt   = '0;
        bit_nxt   = BCW'(NW - 1);
        state_nxt = S_ADJ_DIV;
      end
      S_ADJ_DIV: begin
        rem_nxt = ge ? CNTW'(trial - {1'b0, k_r}) : trial[CNTW-1:0];
        quo_nxt = {quo_r[NW-2:0], ge};
        bit_nxt = bit_r - BCW'(1);
        if (bit_r == '0) begin
          state_nxt = S_ADJ_MIN;
        end
      end
      S_ADJ_MIN: begin
        runmin_nxt = min_sel;
        so_we      = 1'b1;
        so_waddr   = AW'(k_r - CNTW'(1));
        so_wdata   = {min_ext[P_W-1:0], idx_r};
        k_nxt      = k_r - CNTW'(1);
        if (k_r == CNTW'(1)) begin
          e_nxt     = '0;
          state_nxt = S_EM_RD;
        end else begin
          state_nxt = S_ADJ_RD;
        end
      end
      S_EM_RD: begin
        so_raddr  = e_r;
        state_nxt = S_EM_LD;
      end
      S_EM_LD: begin
        out_valid_nxt = 1'b1;
        pos_nxt       = POS_W'(so_rdata[AW-1:0]);
        adj_nxt       = so_rdata[SW-1:AW];
        olast_nxt     = (e_r == last_idx);
        state_nxt     = S_EM_HOLD;
      end
      S_EM_HOLD: begin
        // Hold the result until the consumer takes it.
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (olast_r) begin
            cnt_nxt    = '0;
            runmin_nxt = ONE_R;
            state_nxt  = S_IDLE;
          end else begin
            e_nxt     = e_r + AW'(1);
            state_nxt = S_EM_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      runmin_r    <= ONE_R;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      runmin_r    <= runmin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r     <= m_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    rank_r  <= rank_nxt;
    vi_r    <= vi_nxt;
    k_r     <= k_nxt;
    idx_r   <= idx_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    bit_r   <= bit_nxt;
    e_r     <= e_nxt;
    pos_r   <= pos_nxt;
    adj_r   <= adj_nxt;
    olast_r <= olast_nxt;
  end

endmodule

### sv/fdr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FDR adjuster checker
// Port-level properties of the adjuster, bound to the top level.
// ----------------------------------------------------------------------------
`include "fdr_pvalue_adjuster_macros.svh"

module fdr_checker #(
  parameter int MAX_TERMS = 64
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [fdr_pkg::P_W-1:0]   in_p_value,
  input logic                      in_last_in,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [fdr_pkg::POS_W-1:0] out_term_position,
  input logic [fdr_pkg::P_W-1:0]   out_adjusted_p,
  input logic                      out_last_out
);
  import fdr_pkg::*;

  // No new request is taken while results are going out.
  `FDR_ASSERT_NOW(a_busy_while_out, out_valid, in_stall)
  // A set-closing request starts a run, which raises in_stall.
  `FDR_ASSERT_NEXT(a_run_starts, in_valid && !in_stall && in_last_in, in_stall)
  // Positions stay inside the store.
  `FDR_ASSERT_NOW(a_pos_range, out_valid,
                  {26'd0, out_term_position} < MAX_TERMS)
  // A stalled result holds.
  `FDR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_adjusted_p) && $stable(out_last_out))

endmodule

bind fdr_pvalue_adjuster fdr_checker #(.MAX_TERMS(MAX_TERMS)) u_fdr_checker (.*);
